/* rtl/core/nmc_pkg.sv */
// Package for the normal map classifier: shared widths, register indexes and the
// control/status structs of the serial multiplier. It has no dependencies.
package nmc_pkg;

  // Serial multiplier operand and product widths
  localparam int MUL_AW = 60;
  localparam int MUL_BW = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_SUPPORTED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCEPTED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH_PCT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH_PCT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z_PCT        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_RATIO_PCT = 3'd6;

  // Field widths and saturation limits
  localparam int CNT_W = 13;
  localparam int SUM_W = 21;
  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [SUM_W-1:0] SUM_MAX   = 21'd2097151;

  // Scale of a squared hundredth, and of a squared byte span
  localparam logic [13:0] PCT_SQ_SCALE  = 14'd10000;
  localparam logic [15:0] BYTE_SPAN_SQ  = 16'd65025;

  typedef struct packed {
    logic              start;
    logic              acc;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MUL_AW-1:0] p;
  } mul_sts_t;

endpackage

/* rtl/core/nmc_mul.sv */
// Shift-add serial multiplier for the classifier verdict: one multiplier bit per
// cycle, optional accumulation onto the previous product. Depends on nmc_pkg.
module nmc_mul (
  input  logic             clk,
  input  logic             rst,
  input  nmc_pkg::mul_ctl_t ctl,
  output nmc_pkg::mul_sts_t sts
);
  import nmc_pkg::*;

  logic              busy;
  logic              done;
  logic [MUL_AW-1:0] areg;
  logic [MUL_BW-1:0] breg;
  logic [MUL_AW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && breg == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      areg <= ctl.a;
      breg <= ctl.b;
      if (!ctl.acc) begin
        prod <= '0;
      end
    end else if (busy && breg != '0) begin
      if (breg[0]) begin
        prod <= prod + areg;
      end
      areg <= areg << 1;
      breg <= breg >> 1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.p    = prod;

endmodule

/* rtl/core/normal_map_classifier.sv */
// Normal map classifier top level: pixel classification, accumulators, and the
// verdict sequencer around the shared serial multiplier. Depends on nmc_pkg, nmc_mul.
//
// Usage:
//   Slave stream s_*: one sampled pixel per word. s_tdata holds byte0..byte3 in
//   memory order, s_tuser says the word carries a pixel (0 = bare end marker),
//   s_tlast marks the final word of the image and triggers the verdict.
//   Master stream m_*: one word per image, sent after the word with s_tlast.
//   cfg_we/cfg_index/cfg_data write one register per cycle, no read-back.
// Sequence:
//   A pixel word runs through byte squares, scaled compare and counter update;
//   s_tready is high only while the block waits for a word.
//   The last word then runs the verdict: prepare, form differences, then nine
//   products on the serial multiplier, one multiplier bit (up to 23) per cycle,
//   each issued and drained in turn, before the word is loaded for output.
// Reset: clears counters, sums, the output word and restores register defaults.
// Stall: the result waits in the output register; the next image's pixels are
//   taken meanwhile, and only a following verdict holds until m_tready drains it.
module normal_map_classifier #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // byte0, byte1, byte2, byte3
  input  logic                            s_tuser,   // has_sample
  input  logic                            s_tlast,
  // Verdict output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // is_normal_map, accepted_count,
                                                     // rejected_count, zero pad
  // Configuration
  input  logic                            cfg_we,
  input  logic [nmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nmc_pkg::*;

  // Width of the sample total compared against the capacity
  localparam int CAP_W = $clog2(MAX_SAMPLES + 1);
  localparam int TOT_W = (CAP_W > CNT_W + 1) ? CAP_W : CNT_W + 1;
  localparam logic [TOT_W-1:0] CAP_V = TOT_W'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_CMP, ST_UPD,
    ST_V_PREP, ST_V_DIFF, ST_V_ISSUE, ST_V_WAIT, ST_V_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_DZ, OP_DR, OP_DG, OP_M2, OP_L2S, OP_TMIN, OP_TMAX, OP_Z1, OP_Z2
  } op_t;

  state_t state;
  op_t    op;

  // Configuration registers
  logic        bgr_order;
  logic        format_supported;
  logic [10:0] min_accepted;
  logic [7:0]  min_length_pct;
  logic [7:0]  max_length_pct;
  logic [6:0]  min_z_pct;
  logic [6:0]  reject_ratio_pct;

  // Current pixel
  logic [7:0]  pr, pg, pb, pa;
  logic        has_q, last_q;
  logic [15:0] sq_r, sq_g, sq_b;
  logic [15:0] lmin2;
  logic [31:0] pix_lhs, pix_rhs;

  // Accumulators
  logic [CNT_W-1:0] accepted_total, rejected_total;
  logic [SUM_W-1:0] red_sum, green_sum, blue_sum;

  // Verdict datapath
  logic [SUM_W-1:0] m_val;
  logic             pre_ok, ratio_ok, pass;
  logic [19:0]      rej100, ratio_n;
  logic [22:0]      dr_mag, dg_mag, dz_mag;
  logic             dz_neg;
  logic [15:0]      lmax2;
  logic [13:0]      zmin2;
  logic [43:0]      dz2;
  logic [45:0]      l2;
  logic [41:0]      m2;
  logic [MUL_AW-1:0] l2s;

  // Output word
  logic             out_verdict;
  logic [CNT_W-1:0] out_acc, out_rej;

  mul_ctl_t mul_ctl;
  mul_sts_t mul_sts;

  logic             accept_in;
  logic             load_out;
  logic [TOT_W-1:0] total;
  logic             ignore_pix;
  logic             reject_pix;
  logic signed [23:0] d_r, d_g, d_z;

  // |2x-255| for a byte, always odd
  function automatic logic [7:0] span_mag(input logic [7:0] x);
    span_mag = {(x[7] ? x[6:0] : ~x[6:0]), 1'b1};
  endfunction

  assign accept_in = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign load_out  = (state == ST_V_DONE) && (!m_tvalid || m_tready);
  assign total     = TOT_W'(accepted_total) + TOT_W'(rejected_total);
  assign ignore_pix = (pr == 8'd0 && pg == 8'd0 && pb == 8'd0) || pa == 8'd0;
  assign reject_pix = !pb[7] || (pix_lhs < pix_rhs);

  // Signed offsets 2*sum - 255*n of the average vector
  assign d_r = $signed({2'b00, red_sum, 1'b0})   - $signed({3'b000, m_val});
  assign d_g = $signed({2'b00, green_sum, 1'b0}) - $signed({3'b000, m_val});
  assign d_z = $signed({2'b00, blue_sum, 1'b0})  - $signed({3'b000, m_val});

  // Operand select for the shared multiplier
  always_comb begin
    mul_ctl.start = (state == ST_V_ISSUE);
    mul_ctl.acc   = 1'b0;
    mul_ctl.a     = '0;
    mul_ctl.b     = '0;
    case (op)
      OP_DZ: begin
        mul_ctl.a = MUL_AW'(dz_mag);
        mul_ctl.b = MUL_BW'(dz_mag);
      end
      OP_DR: begin
        mul_ctl.acc = 1'b1;
        mul_ctl.a   = MUL_AW'(dr_mag);
        mul_ctl.b   = MUL_BW'(dr_mag);
      end
      OP_DG: begin
        mul_ctl.acc = 1'b1;
        mul_ctl.a   = MUL_AW'(dg_mag);
        mul_ctl.b   = MUL_BW'(dg_mag);
      end
      OP_M2: begin
        mul_ctl.a = MUL_AW'(m_val);
        mul_ctl.b = MUL_BW'(m_val);
      end
      OP_L2S: begin
        mul_ctl.a = MUL_AW'(l2);
        mul_ctl.b = MUL_BW'(PCT_SQ_SCALE);
      end
      OP_TMIN: begin
        mul_ctl.a = MUL_AW'(m2);
        mul_ctl.b = MUL_BW'(lmin2);
      end
      OP_TMAX: begin
        mul_ctl.a = MUL_AW'(m2);
        mul_ctl.b = MUL_BW'(lmax2);
      end
      OP_Z1: begin
        mul_ctl.a = MUL_AW'(dz2);
        mul_ctl.b = MUL_BW'(PCT_SQ_SCALE);
      end
      OP_Z2: begin
        mul_ctl.a = MUL_AW'(l2);
        mul_ctl.b = MUL_BW'(zmin2);
      end
      default: begin
        mul_ctl.a = '0;
        mul_ctl.b = '0;
      end
    endcase
  end

  nmc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .ctl (mul_ctl),
    .sts (mul_sts)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bgr_order        <= 1'b0;
      format_supported <= 1'b1;
      min_accepted     <= 11'd1;
      min_length_pct   <= 8'd70;
      max_length_pct   <= 8'd110;
      min_z_pct        <= 7'd80;
      reject_ratio_pct <= 7'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BGR_ORDER:        bgr_order        <= cfg_data[0];
        CFG_FORMAT_SUPPORTED: format_supported <= cfg_data[0];
        CFG_MIN_ACCEPTED:     min_accepted     <= cfg_data;
        CFG_MIN_LENGTH_PCT:   min_length_pct   <= cfg_data[7:0];
        CFG_MAX_LENGTH_PCT:   max_length_pct   <= cfg_data[7:0];
        CFG_MIN_Z_PCT:        min_z_pct        <= cfg_data[6:0];
        CFG_REJECT_RATIO_PCT: reject_ratio_pct <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer, accumulators and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_DZ;
      accepted_total <= '0;
      rejected_total <= '0;
      red_sum        <= '0;
      green_sum      <= '0;
      blue_sum       <= '0;
      m_tvalid       <= 1'b0;
      out_verdict    <= 1'b0;
      out_acc        <= '0;
      out_rej        <= '0;
    end else begin
      // Raise valid on a verdict load, drop it once the receiver takes the word
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept_in) begin
            // Swap red and blue in BGR order
            pr     <= bgr_order ? s_tdata[23:16] : s_tdata[7:0];
            pg     <= s_tdata[15:8];
            pb     <= bgr_order ? s_tdata[7:0] : s_tdata[23:16];
            pa     <= s_tdata[31:24];
            has_q  <= s_tuser;
            last_q <= s_tlast;
            state  <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_r  <= span_mag(pr) * span_mag(pr);
          sq_g  <= span_mag(pg) * span_mag(pg);
          sq_b  <= span_mag(pb) * span_mag(pb);
          lmin2 <= min_length_pct * min_length_pct;
          state <= ST_CMP;
        end
        ST_CMP: begin
          // Per-sample length test scaled to integers
          pix_lhs <= (32'(sq_r) + 32'(sq_g) + 32'(sq_b)) * 32'(PCT_SQ_SCALE);
          pix_rhs <= lmin2 * BYTE_SPAN_SQ;
          state   <= ST_UPD;
        end
        ST_UPD: begin
          if (has_q && !ignore_pix && total < CAP_V) begin
            if (reject_pix) begin
              if (rejected_total != COUNT_MAX) begin
                rejected_total <= rejected_total + 1'b1;
              end
            end else begin
              if (accepted_total != COUNT_MAX) begin
                accepted_total <= accepted_total + 1'b1;
              end
              red_sum   <= ({1'b0, red_sum} + 22'(pr) > 22'(SUM_MAX)) ? SUM_MAX
                           : red_sum + SUM_W'(pr);
              green_sum <= ({1'b0, green_sum} + 22'(pg) > 22'(SUM_MAX)) ? SUM_MAX
                           : green_sum + SUM_W'(pg);
              blue_sum  <= ({1'b0, blue_sum} + 22'(pb) > 22'(SUM_MAX)) ? SUM_MAX
                           : blue_sum + SUM_W'(pb);
            end
          end
          state <= last_q ? ST_V_PREP : ST_IDLE;
        end
        ST_V_PREP: begin
          m_val   <= {accepted_total, 8'd0} - SUM_W'(accepted_total);
          pre_ok  <= format_supported && accepted_total != '0
                     && accepted_total >= CNT_W'(min_accepted);
          rej100  <= 20'(rejected_total) * 20'(7'd100);
          ratio_n <= reject_ratio_pct * accepted_total;
          lmax2   <= max_length_pct * max_length_pct;
          zmin2   <= min_z_pct * min_z_pct;
          state   <= ST_V_DIFF;
        end
        ST_V_DIFF: begin
          ratio_ok <= rej100 <= ratio_n;
          dr_mag   <= d_r[23] ? 23'(-d_r) : d_r[22:0];
          dg_mag   <= d_g[23] ? 23'(-d_g) : d_g[22:0];
          dz_mag   <= d_z[23] ? 23'(-d_z) : d_z[22:0];
          dz_neg   <= d_z[23];
          pass     <= 1'b1;
          op       <= OP_DZ;
          state    <= ST_V_ISSUE;
        end
        ST_V_ISSUE: begin
          state <= ST_V_WAIT;
        end
        ST_V_WAIT: begin
          if (mul_sts.done) begin
            state <= ST_V_ISSUE;
            case (op)
              OP_DZ: begin
                dz2 <= mul_sts.p[43:0];
                op  <= OP_DR;
              end
              OP_DR: begin
                op <= OP_DG;
              end
              OP_DG: begin
                // Sum of squares now complete
                l2 <= mul_sts.p[45:0];
                if (mul_sts.p == '0 || dz_neg) begin
                  pass <= 1'b0;
                end
                op <= OP_M2;
              end
              OP_M2: begin
                m2 <= mul_sts.p[41:0];
                op <= OP_L2S;
              end
              OP_L2S: begin
                l2s <= mul_sts.p;
                op  <= OP_TMIN;
              end
              OP_TMIN: begin
                if (l2s < mul_sts.p) begin
                  pass <= 1'b0;
                end
                op <= OP_TMAX;
              end
              OP_TMAX: begin
                if (l2s > mul_sts.p) begin
                  pass <= 1'b0;
                end
                op <= OP_Z1;
              end
              OP_Z1: begin
                // Reuse the scaled length register for the scaled z square
                l2s <= mul_sts.p;
                op  <= OP_Z2;
              end
              OP_Z2: begin
                if (l2s < mul_sts.p) begin
                  pass <= 1'b0;
                end
                state <= ST_V_DONE;
              end
              default: begin
                state <= ST_V_DONE;
              end
            endcase
          end
        end
        ST_V_DONE: begin
          // Hold the verdict until the output register is free
          if (load_out) begin
            out_verdict    <= pre_ok && ratio_ok && pass;
            out_acc        <= accepted_total;
            out_rej        <= rejected_total;
            accepted_total <= '0;
            rejected_total <= '0;
            red_sum        <= '0;
            green_sum      <= '0;
            blue_sum       <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {5'd0, out_rej, out_acc, out_verdict};

`ifndef SYNTHESIS
  // The multiplier only reports back while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> state == ST_V_WAIT)
    else $error("multiplier done outside of wait state");

  // Classification stops at capacity
  assert property (@(posedge clk) disable iff (rst)
    total <= CAP_V)
    else $error("sample total beyond capacity");

  // Accumulators clear together with the verdict load
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> accepted_total == '0 && rejected_total == '0 && blue_sum == '0)
    else $error("accumulators not cleared after verdict");

  // No pixel is taken while a verdict is in flight
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !mul_sts.busy)
    else $error("input ready while multiplier busy");
`endif

endmodule

/* test/normal_map_classifier_tb.sv */
// Self-checking testbench for normal_map_classifier: drives pixel words, predicts
// each image verdict and compares it with the verdict stream. Depends on nmc_pkg.
`timescale 1ns / 100ps

module normal_map_classifier_tb;
  import nmc_pkg::*;

  localparam int MAX_SAMPLES   = 4096;
  localparam int SETTLE_CYCLES = 300;   // longest verdict run plus margin
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 45;

  // One pixel word as it travels on the slave stream
  typedef struct packed {
    logic       last;
    logic       has_px;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } pixel_word_t;

  // Verdict word, laid out as m_tdata from bit 0 up
  typedef struct packed {
    logic [12:0] rej;
    logic [12:0] acc;
    logic        is_nm;
  } verdict_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [10:0]          val;
    pixel_word_t          px;
    logic                 typed;
    verdict_t             exp;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // byte0, byte1, byte2, byte3
  logic                  s_tuser;   // has_sample
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // is_normal_map, accepted_count, rejected_count, pad
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  normal_map_classifier #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow registers of the classifier
  logic        swap_rb;
  logic        fmt_ok;
  logic [10:0] need_accepted;
  logic [7:0]  len_floor_pct;
  logic [7:0]  len_ceil_pct;
  logic [6:0]  z_floor_pct;
  logic [6:0]  ratio_cap_pct;

  // Shadow accumulators of the image in progress
  logic [12:0] n_acc;
  logic [12:0] n_rej;
  logic [20:0] sum_r;
  logic [20:0] sum_g;
  logic [20:0] sum_b;

  verdict_t pending_verdicts[$];
  int       fails;
  int       gap_pct;   // chance of an idle burst per word on either side; 0 = none

  function automatic void clear_image();
    n_acc = '0;
    n_rej = '0;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
    case (idx)
      CFG_BGR_ORDER:        swap_rb       = val[0];
      CFG_FORMAT_SUPPORTED: fmt_ok        = val[0];
      CFG_MIN_ACCEPTED:     need_accepted = val[10:0];
      CFG_MIN_LENGTH_PCT:   len_floor_pct = val[7:0];
      CFG_MAX_LENGTH_PCT:   len_ceil_pct  = val[7:0];
      CFG_MIN_Z_PCT:        z_floor_pct   = val[6:0];
      CFG_REJECT_RATIO_PCT: ratio_cap_pct = val[6:0];
      default: ;
    endcase
  endfunction

  function automatic logic [20:0] sat_sum(input logic [20:0] acc, input logic [7:0] v);
    logic [21:0] s;
    s = acc + v;
    return (s > SUM_MAX) ? SUM_MAX : s[20:0];
  endfunction

  // Classify one pixel in r, g, b, a order and fold it into the image totals
  function automatic void tally_pixel(input logic [7:0] r, g, b, a);
    int              dr, dg, db;
    longint unsigned mag2, floor2;
    if ((r == 0 && g == 0 && b == 0) || a == 0) return;
    // past capacity the pixel is not classified at all
    if (int'(n_acc) + int'(n_rej) >= MAX_SAMPLES) return;
    dr = 2 * int'(r) - 255;
    dg = 2 * int'(g) - 255;
    db = 2 * int'(b) - 255;
    mag2 = dr * dr + dg * dg + db * db;
    floor2 = len_floor_pct;
    floor2 = floor2 * floor2 * 65025;
    if (b <= 127 || mag2 * 10000 < floor2) begin
      n_rej = (n_rej == COUNT_MAX) ? n_rej : n_rej + 13'd1;
    end else begin
      n_acc = (n_acc == COUNT_MAX) ? n_acc : n_acc + 13'd1;
      sum_r = sat_sum(sum_r, r);
      sum_g = sat_sum(sum_g, g);
      sum_b = sat_sum(sum_b, b);
    end
  endfunction

  // Judge the average vector of the image in progress
  function automatic bit judge_image();
    longint          m, dr, dg, dz, sr, sg, sb;
    longint unsigned nu, ru, k, l2, l2s, m2, zz;
    nu = n_acc;
    ru = n_rej;
    if (!fmt_ok || nu == 0 || nu < need_accepted) return 1'b0;
    k = ratio_cap_pct;
    if (ru * 100 > k * nu) return 1'b0;
    sr = sum_r;
    sg = sum_g;
    sb = sum_b;
    m  = 255 * longint'(nu);
    dr = 2 * sr - m;
    dg = 2 * sg - m;
    dz = 2 * sb - m;
    l2  = dr * dr + dg * dg + dz * dz;
    m2  = m * m;
    l2s = l2 * 10000;
    // zero-length or downward average has no usable z
    if (l2 == 0 || dz < 0) return 1'b0;
    k = len_floor_pct;
    if (l2s < k * k * m2) return 1'b0;
    k = len_ceil_pct;
    if (l2s > k * k * m2) return 1'b0;
    k  = z_floor_pct;
    zz = dz * dz;
    return (zz * 10000 >= k * k * l2);
  endfunction

  // Advance the shadow state by one accepted word; a last word yields a verdict
  function automatic void predict_word(input pixel_word_t w, output verdict_t v,
                                       output bit emits);
    v = '0;
    if (w.has_px) begin
      if (swap_rb) tally_pixel(w.b2, w.b1, w.b0, w.b3);
      else         tally_pixel(w.b0, w.b1, w.b2, w.b3);
    end
    emits = w.last;
    if (!emits) return;
    v.is_nm = judge_image();
    v.acc   = n_acc;
    v.rej   = n_rej;
    clear_image();
  endfunction

  // Table row builders
  function automatic stim_row_t pix(input logic [7:0] b0, b1, b2, b3,
                                    input logic has_px, last);
    stim_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.px   = '{last, has_px, b3, b2, b1, b0};
    return row;
  endfunction

  function automatic stim_row_t chk(input stim_row_t row, input logic is_nm,
                                    input logic [12:0] acc, rej);
    stim_row_t r;
    r       = row;
    r.typed = 1'b1;
    r.exp   = '{rej, acc, is_nm};
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [10:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // Random pixel word; structured kinds follow the current byte order
  function automatic pixel_word_t make_word(input bit noisy, input bit last);
    pixel_word_t w;
    int          pick;
    logic [7:0]  r, g, b, a;
    w = '0;
    {w.b3, w.b2, w.b1, w.b0} = $urandom;
    w.last = last;
    pick = $urandom_range(0, 99);
    if (noisy) begin
      w.has_px = ($urandom_range(0, 7) != 0);
      return w;
    end
    if (last && pick < 20) begin
      w.has_px = 1'b0;
      return w;
    end
    w.has_px = 1'b1;
    if (pick < 8) return w;
    a = 8'($urandom_range(1, 255));
    r = 8'($urandom_range(68, 188));
    g = 8'($urandom_range(68, 188));
    b = 8'($urandom_range(215, 255));
    if (pick < 13) begin
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
      a = 8'($urandom);
    end else if (pick < 18) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      a = 8'd0;
    end else if (pick < 25) begin
      b = 8'($urandom_range(0, 127));
    end
    w.b0 = swap_rb ? b : r;
    w.b1 = g;
    w.b2 = swap_rb ? r : b;
    w.b3 = a;
    return w;
  endfunction

  // Present one word, hold it until taken, then record what it should produce
  task automatic send_word(input pixel_word_t w, input logic typed, input verdict_t typed_v);
    verdict_t v;
    bit       emits;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.b3, w.b2, w.b1, w.b0};
    s_tuser  <= w.has_px;
    s_tlast  <= w.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(w, v, emits);
    if (emits) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    store_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [10:0] bgr, fmt, min_acc, min_len, max_len,
                              min_z, ratio);
    write_reg(CFG_BGR_ORDER, bgr);
    write_reg(CFG_FORMAT_SUPPORTED, fmt);
    write_reg(CFG_MIN_ACCEPTED, min_acc);
    write_reg(CFG_MIN_LENGTH_PCT, min_len);
    write_reg(CFG_MAX_LENGTH_PCT, max_len);
    write_reg(CFG_MIN_Z_PCT, min_z);
    write_reg(CFG_REJECT_RATIO_PCT, ratio);
  endtask

  // Receiver side: drop tready in random bursts while idling is on
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare every verdict word taken with the oldest one predicted
  always @(posedge clk) begin : verdict_check
    verdict_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[26:0];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict word %h with none expected", $time, m_tdata);
        fails++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.is_nm !== want.is_nm) begin
          $display("%0t: is_normal_map expected %0d actual %0d", $time, want.is_nm, got.is_nm);
          fails++;
        end
        if (got.acc !== want.acc) begin
          $display("%0t: accepted_count expected %0d actual %0d", $time, want.acc, got.acc);
          fails++;
        end
        if (got.rej !== want.rej) begin
          $display("%0t: rejected_count expected %0d actual %0d", $time, want.rej, got.rej);
          fails++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   plan [23];
    pixel_word_t w;
    int          sent, len;
    bit          noisy;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fails     = 0;
    gap_pct   = 30;
    // register defaults after reset
    swap_rb       = 1'b0;
    fmt_ok        = 1'b1;
    need_accepted = 11'd1;
    len_floor_pct = 8'd70;
    len_ceil_pct  = 8'd110;
    z_floor_pct   = 7'd80;
    ratio_cap_pct = 7'd33;
    clear_image();

    // Directed table: byte0..byte3, has_sample, last; typed verdicts where obvious
    plan = '{
      // end marker straight after reset: nothing accepted, no positive verdict
      chk(pix(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, 13'd0, 13'd0),
      pix(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0),          // black: ignored
      pix(8'd128, 8'd128, 8'd255, 8'd0, 1'b1, 1'b0),      // transparent: ignored
      pix(8'd128, 8'd128, 8'd255, 8'd255, 1'b1, 1'b0),    // straight up: accepted
      pix(8'd255, 8'd255, 8'd127, 8'd255, 1'b1, 1'b0),    // blue at 127: rejected
      pix(8'd128, 8'd128, 8'd128, 8'd255, 1'b1, 1'b0),    // near-zero vector: rejected
      // too many rejects for the ratio limit
      chk(pix(8'd128, 8'd128, 8'd255, 8'd255, 1'b1, 1'b1), 1'b0, 13'd2, 13'd2),
      pix(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0),    // all bytes high
      // averages to exactly +z
      chk(pix(8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b1), 1'b1, 13'd2, 13'd0),
      chk(pix(8'd128, 8'd128, 8'd255, 8'd255, 1'b1, 1'b1), 1'b1, 13'd1, 13'd0),
      reg_row(CFG_BGR_ORDER, 11'd1),
      chk(pix(8'd255, 8'd128, 8'd128, 8'd255, 1'b1, 1'b1), 1'b1, 13'd1, 13'd0),
      // swapped order turns this into a sideways vector: z too small
      chk(pix(8'd128, 8'd128, 8'd255, 8'd255, 1'b1, 1'b1), 1'b0, 13'd1, 13'd0),
      reg_row(CFG_FORMAT_SUPPORTED, 11'd0),
      // unsupported format still reports its counts
      chk(pix(8'd255, 8'd128, 8'd128, 8'd255, 1'b1, 1'b1), 1'b0, 13'd1, 13'd0),
      reg_row(CFG_FORMAT_SUPPORTED, 11'd1),
      reg_row(CFG_BGR_ORDER, 11'd0),
      reg_row(CFG_MIN_ACCEPTED, 11'd0),
      // zero minimum does not let an empty image through
      chk(pix(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, 13'd0, 13'd0),
      reg_row(CFG_MIN_LENGTH_PCT, 11'd0),
      pix(8'd128, 8'd128, 8'd128, 8'd255, 1'b1, 1'b1),    // tiny vector now accepted
      reg_row(CFG_MIN_LENGTH_PCT, 11'd70),
      reg_row(CFG_MIN_ACCEPTED, 11'd1)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].val);
      else send_word(plan[i].px, plan[i].typed, plan[i].exp);
    end

    // Random images under a range of settings, extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(11'd0, 11'd1, 11'd1, 11'd70, 11'd110, 11'd80, 11'd33);
        1: program_regs(11'd0, 11'd1, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        2: program_regs(11'd1, 11'd1, 11'd2047, 11'd255, 11'd255, 11'd127, 11'd127);
        3: program_regs(11'($urandom_range(0, 1)), 11'd0, 11'($urandom_range(1, 4)),
                        11'd70, 11'd110, 11'd80, 11'd33);
        default: program_regs(11'($urandom_range(0, 1)), 11'($urandom_range(0, 9) != 0),
                              11'($urandom_range(1, 6)), 11'($urandom_range(40, 90)),
                              11'($urandom_range(95, 200)), 11'($urandom_range(50, 100)),
                              11'($urandom_range(0, 100)));
      endcase
      // every third phase, and the closing one, runs with no idling at all
      gap_pct = (p % 3 == 2 || p == PHASES - 1) ? 0 : 30;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        noisy = ($urandom_range(0, 6) == 0);
        for (int k = 0; k < len; k++) begin
          w = make_word(noisy, k == len - 1);
          send_word(w, 1'b0, '0);
        end
        sent += len;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending_verdicts.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
